// ===== rtl/core/hpq_pkg.sv =====
// Shared constants, types and helpers of the max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

package hpq_pkg;

   localparam int CAPACITY  = 128;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int POS_W     = CNT_W + 1;
   localparam int KEY_W     = 32;
   localparam int STATUS_W  = 2;
   localparam int ENTRIES_W = 8;

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [KEY_W-1:0]  key_out;
      logic [STATUS_W-1:0]      status;
      logic [ENTRIES_W-1:0]     entries;
   } rsp_word_type;

   // Heap positions are 1-based; the memory is addressed from zero.
   function automatic logic [ADDR_W-1:0] pos_addr(input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] offset;
      offset = pos - POS_W'(1);
      return offset[ADDR_W-1:0];
   endfunction

   function automatic logic [ENTRIES_W-1:0] entries_of(input logic [CNT_W-1:0] count);
      return ENTRIES_W'(count);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hpq_req_if.sv =====
// Request channel of the priority queue: operation and key with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface hpq_req_if
   import hpq_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    op;
   logic signed [KEY_W-1:0] key_in;

   modport source (output valid, output op, output key_in, input ready);
   modport sink   (input valid, input op, input key_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hpq_rsp_if.sv =====
// Response channel of the priority queue: removed key, status and entry count.
`timescale 1ns / 1ps
`default_nettype none

interface hpq_rsp_if
   import hpq_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] key_out;
   logic [STATUS_W-1:0]     status;
   logic [ENTRIES_W-1:0]    entries;

   modport source (output valid, output key_out, output status, output entries,
                   input ready);
   modport sink   (input valid, input key_out, input status, input entries,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hpq_ram.sv =====
// Generic synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module hpq_ram #(
   parameter int  DATA_W = 32,
   parameter int  DEPTH  = 128,
   localparam int AW     = $clog2(DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic signed [DATA_W-1:0] wr_data,
   input  wire logic                     rd_a_en,
   input  wire logic [AW-1:0]            rd_a_addr,
   output      logic signed [DATA_W-1:0] rd_a_data,
   input  wire logic                     rd_b_en,
   input  wire logic [AW-1:0]            rd_b_addr,
   output      logic signed [DATA_W-1:0] rd_b_data
);

   logic signed [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_data <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data <= mem[rd_b_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/hpq_ctrl.sv =====
// Sift sequencer: walks the heap in memory one level per read/compare pair.
`timescale 1ns / 1ps
`default_nettype none

module hpq_ctrl
   import hpq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic                    req_op,
   input  wire logic signed [KEY_W-1:0] req_key_in,
   output      logic                    done,
   output      rsp_word_type            done_word,
   input  wire logic                    out_free
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_UP_RD   = 8'b0000_0010,
      S_UP_CMP  = 8'b0000_0100,
      S_DN_INIT = 8'b0000_1000,
      S_DN_LOAD = 8'b0001_0000,
      S_DN_RD   = 8'b0010_0000,
      S_DN_CMP  = 8'b0100_0000,
      S_FIN     = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic signed [KEY_W-1:0] mov_ff, mov_in;
   rsp_word_type            res_ff, res_in;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic signed [KEY_W-1:0] wr_data;
   logic                    rd_a_en, rd_b_en;
   logic [ADDR_W-1:0]       rd_a_addr, rd_b_addr;
   logic signed [KEY_W-1:0] rd_a_data, rd_b_data;

   logic [POS_W-1:0]        pos_ext, count_ext, left_pos, right_pos;
   logic [CNT_W-1:0]        parent_pos, count_dec;
   logic signed [KEY_W-1:0] best_key;
   logic                    take_left, take_right;

   hpq_ram #(
      .DATA_W (KEY_W),
      .DEPTH  (CAPACITY)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_en   (rd_a_en),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_en   (rd_b_en),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   assign pos_ext    = POS_W'(pos_ff);
   assign count_ext  = POS_W'(count_ff);
   assign left_pos   = {pos_ff, 1'b0};
   assign right_pos  = {pos_ff, 1'b1};
   assign parent_pos = pos_ff >> 1;
   assign count_dec  = count_ff - CNT_W'(1);

   // Left child wins ties; the right child must beat the best so far.
   always_comb begin
      take_left  = (left_pos <= count_ext) && (rd_a_data > mov_ff);
      best_key   = take_left ? rd_a_data : mov_ff;
      take_right = (right_pos <= count_ext) && (rd_b_data > best_key);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign done      = (state_ff == S_FIN);
   assign done_word = res_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      mov_in    = mov_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_addr(pos_ext);
      wr_data   = mov_ff;
      rd_a_en   = 1'b0;
      rd_a_addr = '0;
      rd_b_en   = 1'b0;
      rd_b_addr = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_PUSH) begin
                  if (count_ff == CAP_COUNT) begin
                     res_in   = '{key_out: '0, status: STATUS_FULL,
                                  entries: entries_of(count_ff)};
                     state_in = S_FIN;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                     pos_in   = count_ff + CNT_W'(1);
                     mov_in   = req_key_in;
                     res_in   = '{key_out: '0, status: STATUS_OK,
                                  entries: entries_of(count_ff + CNT_W'(1))};
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in   = '{key_out: '0, status: STATUS_EMPTY,
                                  entries: entries_of(count_ff)};
                     state_in = S_FIN;
                  end else begin
                     state_in = S_DN_INIT;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == CNT_W'(1)) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               rd_a_en   = 1'b1;
               rd_a_addr = pos_addr(POS_W'(parent_pos));
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (mov_ff > rd_a_data) begin
               wr_data  = rd_a_data;
               pos_in   = parent_pos;
               state_in = S_UP_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DN_INIT: begin
            rd_a_en   = 1'b1;
            rd_a_addr = pos_addr(POS_W'(1));
            rd_b_en   = 1'b1;
            rd_b_addr = pos_addr(count_ext);
            state_in  = S_DN_LOAD;
         end
         S_DN_LOAD: begin
            res_in   = '{key_out: rd_a_data, status: STATUS_OK,
                         entries: entries_of(count_dec)};
            mov_in   = rd_b_data;
            count_in = count_dec;
            pos_in   = CNT_W'(1);
            state_in = (count_dec == '0) ? S_FIN : S_DN_RD;
         end
         S_DN_RD: begin
            if (left_pos > count_ext) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               rd_a_en   = 1'b1;
               rd_a_addr = pos_addr(left_pos);
               rd_b_en   = 1'b1;
               rd_b_addr = pos_addr(right_pos);
               state_in  = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (take_right) begin
               wr_data  = rd_b_data;
               pos_in   = CNT_W'(right_pos);
               state_in = S_DN_RD;
            end else if (take_left) begin
               wr_data  = rd_a_data;
               pos_in   = CNT_W'(left_pos);
               state_in = S_DN_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff <= pos_in;
      mov_ff <= mov_in;
      res_ff <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count exceeds capacity");

   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP_CMP || state_ff == S_DN_CMP) |->
         ($past(state_ff) == S_UP_RD || $past(state_ff) == S_DN_RD))
      else $error("compare step without a preceding memory read");

   a_pos_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP_RD || state_ff == S_UP_CMP ||
       state_ff == S_DN_RD || state_ff == S_DN_CMP) |->
         (pos_ff != '0 && pos_ext <= count_ext))
      else $error("sift position outside the occupied heap");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_PUSH && count_ff != CAP_COUNT) |=>
         (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("accepted push did not add an entry");

endmodule

`default_nettype wire

// ===== rtl/core/max_heap_priority_queue.sv =====
// Top level of the max-heap priority queue: channels, sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none

// A binary max-heap priority queue over signed 32-bit keys, held in one
// synchronous memory of CAPACITY words with a second read port. Each request
// word is either a push of key_in or a pop of the largest key, and each one
// yields exactly one response word carrying the removed key (zero unless a pop
// succeeds), a status (ok, pop on empty, push on full) and the number of keys
// held afterwards. A push on a full heap is dropped and a pop on an empty heap
// changes nothing. One word is worked on at a time: the sift moves one level
// per read/compare pair, a memory read followed by a compare and write back.
// A push climbs by reading the parent and writing back either the parent or,
// where it comes to rest, the key. A pop first reads the root and the last
// key, then loads the removed key and the moved key, and sinks the moved key
// by reading both children and writing back the larger child or, where it
// comes to rest, the moved key. For 128 entries a push climbs at most 7
// levels and a pop sinks at most 6. Rejected pushes and empty pops go straight
// from acceptance to the finish state, which loads the response register once
// it is free. The next request is taken in the cycle after the previous
// response enters the output register, even if the sink has not yet taken it.
// The heap memory needs no clearing after reset: only keys from occupied
// positions are ever used.
module max_heap_priority_queue
   import hpq_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   hpq_req_if.sink  req,
   hpq_rsp_if.source rsp
);

   logic         done;
   rsp_word_type done_word;
   logic         out_free;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   hpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_op     (req.op),
      .req_key_in (req.key_in),
      .done       (done),
      .done_word  (done_word),
      .out_free   (out_free)
   );

   // The output register is free when empty or when its word leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = done_word;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.key_out = rsp_word_ff.key_out;
   assign rsp.status  = rsp_word_ff.status;
   assign rsp.entries = rsp_word_ff.entries;

endmodule

`default_nettype wire
